// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the task-file command builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising clock edge outside reset.
`define AT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an expression is never true outside reset.
`define AT_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define AT_ASSERT(lbl, clk, rst, prop, msg)
`define AT_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// ===== rtl/atacb_pkg.sv =====
// Constants, codes and widths of the ATA task-file command builder.
package atacb_pkg;

  localparam int NUM_DRIVES = 4;

  localparam int DRV_W   = 2;
  localparam int DRV_SLOTS = 1 << DRV_W;
  localparam int MASK_W  = 4;
  localparam int LBA_W   = 32;
  localparam int CNT_W   = 8;
  localparam int SEL_W   = 4;
  localparam int ERR_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // floor(2^32 / 63): quotient estimate is exact or one short
  localparam int RECIP_W = 27;
  localparam logic [RECIP_W-1:0] RECIP63 = 27'd68174084;
  localparam int QUO_W = 27;
  localparam logic [6:0] CHS_SPT = 7'd63;

  localparam logic [7:0] DEVSEL_CHS = 8'hA0;
  localparam logic [7:0] DEVSEL_LBA = 8'hE0;

  localparam logic [7:0] CMD_RD_PIO     = 8'h20;
  localparam logic [7:0] CMD_RD_PIO_EXT = 8'h24;
  localparam logic [7:0] CMD_WR_PIO     = 8'h30;
  localparam logic [7:0] CMD_WR_PIO_EXT = 8'h34;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [SEL_W-1:0] REG_DEVSEL    = 4'd0;
  localparam logic [SEL_W-1:0] REG_SECCNT_HI = 4'd1;
  localparam logic [SEL_W-1:0] REG_LBA3      = 4'd2;
  localparam logic [SEL_W-1:0] REG_LBA4      = 4'd3;
  localparam logic [SEL_W-1:0] REG_LBA5      = 4'd4;
  localparam logic [SEL_W-1:0] REG_SECCNT    = 4'd5;
  localparam logic [SEL_W-1:0] REG_LBA0      = 4'd6;
  localparam logic [SEL_W-1:0] REG_LBA1      = 4'd7;
  localparam logic [SEL_W-1:0] REG_LBA2      = 4'd8;
  localparam logic [SEL_W-1:0] REG_COMMAND   = 4'd9;

  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ABSENT  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LBA_CAP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECT0   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SECT1   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SECT2   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SECT3   = 3'd7;

endpackage

// ===== rtl/atacb_if.sv =====
// Request and result channel interfaces of the task-file command builder.
interface atacb_req_if
  import atacb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             op;
  logic [DRV_W-1:0] drive_index;
  logic [LBA_W-1:0] lba;
  logic [CNT_W-1:0] sector_count;

  modport source (output valid, op, drive_index, lba, sector_count, input ready);
  modport sink   (input valid, op, drive_index, lba, sector_count, output ready);
endinterface

interface atacb_res_if
  import atacb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             channel_sel;
  logic [SEL_W-1:0] reg_select;
  logic [7:0]       reg_value;
  logic [ERR_W-1:0] error_code;
  logic             last;

  modport source (output valid, channel_sel, reg_select, reg_value, error_code, last,
                  input ready);
  modport sink   (input valid, channel_sel, reg_select, reg_value, error_code, last,
                  output ready);
endinterface

// ===== rtl/ata_taskfile_command_builder.sv =====
// Top level: ATA PIO task-file command builder (LBA48, LBA28 and CHS setup).
// Usage:
//   req  - one transfer per sector read or write request: op, drive_index,
//          lba, sector_count.
//   res  - one transfer per task-file register write: channel_sel,
//          reg_select, reg_value, error_code, last (set on the final write).
//   cfg  - cfg_we/cfg_index/cfg_data write the drive masks and sizes; write
//          only while no request is in flight.
// Path: a request taken in passes stage registers A, B and C, and then the
//   output register offers its first register write.
// Throughput: the result side moves one register write per cycle while
//   res.ready is high; a request makes 10 register writes (LBA48), 6
//   (LBA28/CHS) or 1 (error), which sets the sustained rate. The three
//   compute stages overlap, so the next request is already built when the
//   last write of the current one transfers out.
// Reset: rst clears all valid bits, the beat counter and every config
//   register (no drive present, all sizes zero).
// Stall: when res.ready is low the current write holds; the stages behind it
//   fill and then drop req.ready. Nothing is lost or repeated.
`include "assert_macros.svh"

module ata_taskfile_command_builder
  import atacb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  atacb_req_if.sink             req,
  atacb_res_if.source           res
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [MASK_W-1:0] present_mask;
  logic [MASK_W-1:0] lba_capable_mask;
  logic [MASK_W-1:0] slave_mask;
  logic [MASK_W-1:0] channel_mask;
  logic [LBA_W-1:0]  sectors [DRV_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      present_mask     <= '0;
      lba_capable_mask <= '0;
      slave_mask       <= '0;
      channel_mask     <= '0;
      for (int i = 0; i < DRV_SLOTS; i++) begin
        sectors[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESENT: present_mask     <= cfg_data[MASK_W-1:0];
        CFG_LBA_CAP: lba_capable_mask <= cfg_data[MASK_W-1:0];
        CFG_SLAVE:   slave_mask       <= cfg_data[MASK_W-1:0];
        CFG_CHANNEL: channel_mask     <= cfg_data[MASK_W-1:0];
        CFG_SECT0:   sectors[0]       <= cfg_data[LBA_W-1:0];
        CFG_SECT1:   sectors[1]       <= cfg_data[LBA_W-1:0];
        CFG_SECT2:   sectors[2]       <= cfg_data[LBA_W-1:0];
        CFG_SECT3:   sectors[3]       <= cfg_data[LBA_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake chain: a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------
  logic a_valid, b_valid, c_valid, e_valid;
  logic a_ready, b_ready, c_ready, e_take;
  logic e_last;

  assign e_take  = !e_valid || (res.ready && e_last);
  assign c_ready = !c_valid || e_take;
  assign b_ready = !b_valid || c_ready;
  assign a_ready = !a_valid || b_ready;
  assign req.ready = a_ready;

  // ---------------------------------------------------------------------
  // Stage A: request register; presence and range check, 1/63 product
  // ---------------------------------------------------------------------
  logic             a_op;
  logic [DRV_W-1:0] a_drive;
  logic [LBA_W-1:0] a_lba;
  logic [CNT_W-1:0] a_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_op    <= req.op;
      a_drive <= req.drive_index;
      a_lba   <= req.lba;
      a_cnt   <= req.sector_count;
    end
  end

  localparam logic [DRV_W:0] DRV_LIMIT = (DRV_W+1)'(NUM_DRIVES);
  localparam int PROD_W = LBA_W + RECIP_W;

  logic [LBA_W:0]    a_sum;
  logic              a_present;
  logic              a_over;
  logic [ERR_W-1:0]  a_err;
  logic [PROD_W-1:0] a_prod;

  always_comb begin
    a_sum     = {1'b0, a_lba} + (LBA_W+1)'(a_cnt);
    a_present = ({1'b0, a_drive} < DRV_LIMIT) && present_mask[a_drive];
    a_over    = a_sum > {1'b0, sectors[a_drive]};
    if (!a_present) begin
      a_err = ERR_ABSENT;
    end else if (a_over) begin
      a_err = ERR_RANGE;
    end else begin
      a_err = ERR_OK;
    end
    a_prod = PROD_W'(a_lba) * PROD_W'(RECIP63);
  end

  // ---------------------------------------------------------------------
  // Stage B: quotient estimate; remainder estimate lba - 63*q
  // ---------------------------------------------------------------------
  logic             b_op;
  logic [ERR_W-1:0] b_err;
  logic [LBA_W-1:0] b_lba;
  logic [CNT_W-1:0] b_cnt;
  logic [QUO_W-1:0] b_q;
  logic             b_ch, b_slave, b_lbacap;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_op     <= a_op;
      b_err    <= a_err;
      b_lba    <= a_lba;
      b_cnt    <= a_cnt;
      b_q      <= a_prod[PROD_W-1:LBA_W];
      b_ch     <= channel_mask[a_drive];
      b_slave  <= slave_mask[a_drive];
      b_lbacap <= lba_capable_mask[a_drive];
    end
  end

  logic [QUO_W+5:0] b_q63;
  logic [LBA_W-1:0] b_rem_full;

  always_comb begin
    // 63*q as (q << 6) - q; the difference from lba stays below 126
    b_q63      = {b_q, 6'b0} - (QUO_W+6)'(b_q);
    b_rem_full = b_lba - b_q63[LBA_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Stage C: correct the remainder, pick the mode, build the bytes
  // ---------------------------------------------------------------------
  logic             c_op;
  logic [ERR_W-1:0] c_err;
  logic [LBA_W-1:0] c_lba;
  logic [CNT_W-1:0] c_cnt;
  logic [19:0]      c_q;
  logic [6:0]       c_rem;
  logic             c_ch, c_slave, c_lbacap;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_op     <= b_op;
      c_err    <= b_err;
      c_lba    <= b_lba;
      c_cnt    <= b_cnt;
      c_q      <= b_q[19:0];
      c_rem    <= b_rem_full[6:0];
      c_ch     <= b_ch;
      c_slave  <= b_slave;
      c_lbacap <= b_lbacap;
    end
  end

  logic        c_fix;
  logic [6:0]  c_sec;
  logic [19:0] c_quo;
  logic        c_ext;
  logic [3:0]  c_head;
  logic [7:0]  c_base, c_b0, c_b1, c_b2, c_b3, c_devsel, c_cmd;

  always_comb begin
    c_fix = c_rem >= CHS_SPT;
    c_sec = c_fix ? (c_rem - CHS_SPT) : c_rem;
    // low 20 bits of lba/63, exact; cylinder is quo/16 and head quo%16
    c_quo = c_q + 20'(c_fix);
    c_ext = |c_lba[31:28];
    c_b3  = c_lba[31:24];
    if (c_ext) begin
      c_b0   = c_lba[7:0];
      c_b1   = c_lba[15:8];
      c_b2   = c_lba[23:16];
      c_head = 4'd0;
      c_base = DEVSEL_LBA;
    end else if (c_lbacap) begin
      c_b0   = c_lba[7:0];
      c_b1   = c_lba[15:8];
      c_b2   = c_lba[23:16];
      c_head = c_lba[27:24];
      c_base = DEVSEL_LBA;
    end else begin
      c_b0   = 8'(c_sec) + 8'd1;
      c_b1   = c_quo[11:4];
      c_b2   = c_quo[19:12];
      c_head = c_quo[3:0];
      c_base = DEVSEL_CHS;
    end
    c_devsel = c_base | {3'b0, c_slave, 4'b0} | {4'b0, c_head};
    if (c_op == OP_WRITE) begin
      c_cmd = c_ext ? CMD_WR_PIO_EXT : CMD_WR_PIO;
    end else begin
      c_cmd = c_ext ? CMD_RD_PIO_EXT : CMD_RD_PIO;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: walk the register writes of one request, one a beat
  // ---------------------------------------------------------------------
  logic [SEL_W-1:0] e_sel;
  logic [ERR_W-1:0] e_err;
  logic             e_ch, e_ext;
  logic [7:0]       e_devsel, e_b3, e_cnt, e_b0, e_b1, e_b2, e_cmd;
  logic [SEL_W-1:0] e_sel_next;

  always_comb begin
    // LBA28 and CHS skip the high-order block after device select
    if (e_sel == REG_DEVSEL && !e_ext) begin
      e_sel_next = REG_SECCNT;
    end else begin
      e_sel_next = e_sel + SEL_W'(1);
    end
  end

  assign e_last = (e_err != ERR_OK) || (e_sel == REG_COMMAND);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      e_sel   <= REG_DEVSEL;
    end else if (e_take) begin
      e_valid <= c_valid;
      e_sel   <= REG_DEVSEL;
    end else if (res.ready) begin
      e_sel   <= e_sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (e_take) begin
      e_err    <= c_err;
      e_ch     <= c_ch;
      e_ext    <= c_ext;
      e_devsel <= c_devsel;
      e_b3     <= c_b3;
      e_cnt    <= c_cnt;
      e_b0     <= c_b0;
      e_b1     <= c_b1;
      e_b2     <= c_b2;
      e_cmd    <= c_cmd;
    end
  end

  logic [7:0] e_value;

  always_comb begin
    case (e_sel)
      REG_DEVSEL:  e_value = e_devsel;
      REG_LBA3:    e_value = e_b3;
      REG_SECCNT:  e_value = e_cnt;
      REG_LBA0:    e_value = e_b0;
      REG_LBA1:    e_value = e_b1;
      REG_LBA2:    e_value = e_b2;
      REG_COMMAND: e_value = e_cmd;
      default:     e_value = 8'd0;
    endcase
  end

  // Error results carry zeros in every field but error_code and last
  assign res.valid       = e_valid;
  assign res.channel_sel = (e_err == ERR_OK) ? e_ch : 1'b0;
  assign res.reg_select  = e_sel;
  assign res.reg_value   = (e_err == ERR_OK) ? e_value : 8'd0;
  assign res.error_code  = e_err;
  assign res.last        = e_last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `AT_ASSERT(a_err_single, clk, rst,
    (res.valid && res.error_code != ERR_OK) |->
      (res.last && res.reg_select == REG_DEVSEL && res.reg_value == 8'd0),
    "error result is not a lone zeroed write")
  `AT_ASSERT(a_beat_continues, clk, rst,
    (res.valid && res.ready && !res.last) |=> res.valid,
    "request ended before its last write")
  `AT_ASSERT(a_sel_order, clk, rst,
    (res.valid && res.ready && !res.last) |=>
      (res.reg_select == $past(res.reg_select) + SEL_W'(1) ||
       ($past(res.reg_select) == REG_DEVSEL && res.reg_select == REG_SECCNT)),
    "register writes out of order")
  `AT_ASSERT(a_rem_bound, clk, rst,
    c_valid |-> (c_rem < 7'd126),
    "quotient estimate off by more than one")

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the ATA task-file command builder: random and directed requests.
module tb;
  import atacb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // CHS geometry and the first LBA that needs the 48-bit command set
  localparam int unsigned TRACK_SECT  = 63;
  localparam int unsigned CYL_SECT    = 16 * 63;
  localparam logic [LBA_W-1:0] LBA48_START = 32'h1000_0000;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic             op;
    logic [DRV_W-1:0] drv;
    logic [LBA_W-1:0] lba;
    logic [CNT_W-1:0] cnt;
  } ata_req_t;

  typedef struct packed {
    logic             ch;
    logic [SEL_W-1:0] sel;
    logic [7:0]       val;
    logic [ERR_W-1:0] err;
    logic             last;
  } tf_write_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  atacb_req_if req_ch ();
  atacb_res_if res_ch ();

  ata_taskfile_command_builder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch.sink),
    .res       (res_ch.source)
  );

  // Shadow copy of the drive setup, updated on every register write
  logic [MASK_W-1:0] present_m;
  logic [MASK_W-1:0] lba_cap_m;
  logic [MASK_W-1:0] slave_m;
  logic [MASK_W-1:0] chan_m;
  logic [LBA_W-1:0]  drive_size [NUM_DRIVES];

  ata_req_t  pending_reqs [$];   // requests waiting for the driver
  tf_write_t writes_due [$];     // task-file writes the block still owes us
  ata_req_t  next_req;
  tf_write_t seen_write;
  tf_write_t due_write;

  int reqs_queued;
  int reqs_taken;
  int fail_count;
  int cycle_count;
  int send_idle_pct;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Append one expected register write; last is patched in afterwards.
  function automatic void owe_write(input logic ch, input logic [SEL_W-1:0] sel,
                                    input logic [7:0] val, input logic [ERR_W-1:0] err);
    writes_due.push_back(tf_write_t'{ch, sel, val, err, 1'b0});
  endfunction

  // Work out the register write sequence that one request must produce.
  function automatic void build_taskfile_writes(input ata_req_t r);
    logic [LBA_W:0]   span_end;
    logic             ch;
    logic             slv;
    logic             ext;
    logic [LBA_W-1:0] rem;
    logic [LBA_W-1:0] base;
    logic [LBA_W-1:0] cyl;
    logic [7:0]       b0, b1, b2, b3, dev_base, cmd;
    logic [3:0]       head;
    span_end = {1'b0, r.lba} + (LBA_W+1)'(r.cnt);
    b3 = 8'h00;
    ext = 1'b0;
    if (int'(r.drv) >= NUM_DRIVES || !present_m[r.drv]) begin
      owe_write(1'b0, REG_DEVSEL, 8'h00, ERR_ABSENT);
    end else if (span_end > {1'b0, drive_size[r.drv]}) begin
      // same 33-bit test for reads and writes
      owe_write(1'b0, REG_DEVSEL, 8'h00, ERR_RANGE);
    end else begin
      ch  = chan_m[r.drv];
      slv = slave_m[r.drv];
      if (r.lba >= LBA48_START) begin
        ext = 1'b1;
        {b3, b2, b1, b0} = r.lba;
        head = 4'h0;
        dev_base = DEVSEL_LBA;
      end else if (lba_cap_m[r.drv]) begin
        b0 = r.lba[7:0];
        b1 = r.lba[15:8];
        b2 = r.lba[23:16];
        head = r.lba[27:24];
        dev_base = DEVSEL_LBA;
      end else begin
        // cylinder keeps only its low 16 bits
        rem  = r.lba % TRACK_SECT;
        base = r.lba - rem;
        cyl  = base / CYL_SECT;
        b0   = 8'(rem + 1);
        b1   = cyl[7:0];
        b2   = cyl[15:8];
        head = 4'((base % CYL_SECT) / TRACK_SECT);
        dev_base = DEVSEL_CHS;
      end
      if (r.op == OP_READ) cmd = ext ? CMD_RD_PIO_EXT : CMD_RD_PIO;
      else                 cmd = ext ? CMD_WR_PIO_EXT : CMD_WR_PIO;
      owe_write(ch, REG_DEVSEL, dev_base | {3'b000, slv, head}, ERR_OK);
      if (ext) begin
        owe_write(ch, REG_SECCNT_HI, 8'h00, ERR_OK);
        owe_write(ch, REG_LBA3, b3, ERR_OK);
        owe_write(ch, REG_LBA4, 8'h00, ERR_OK);
        owe_write(ch, REG_LBA5, 8'h00, ERR_OK);
      end
      owe_write(ch, REG_SECCNT, r.cnt, ERR_OK);
      owe_write(ch, REG_LBA0, b0, ERR_OK);
      owe_write(ch, REG_LBA1, b1, ERR_OK);
      owe_write(ch, REG_LBA2, b2, ERR_OK);
      owe_write(ch, REG_COMMAND, cmd, ERR_OK);
    end
    writes_due[writes_due.size()-1].last = 1'b1;
  endfunction

  // Write one config register and mirror it. Only call while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PRESENT: present_m = data[MASK_W-1:0];
      CFG_LBA_CAP: lba_cap_m = data[MASK_W-1:0];
      CFG_SLAVE:   slave_m   = data[MASK_W-1:0];
      CFG_CHANNEL: chan_m    = data[MASK_W-1:0];
      CFG_SECT0:   drive_size[0] = data;
      CFG_SECT1:   drive_size[1] = data;
      CFG_SECT2:   drive_size[2] = data;
      CFG_SECT3:   drive_size[3] = data;
      default: ;
    endcase
  endtask

  // Load the full drive setup: masks first, then the four drive sizes.
  task automatic load_drive_setup(input logic [MASK_W-1:0] pres, input logic [MASK_W-1:0] cap,
                                  input logic [MASK_W-1:0] slv, input logic [MASK_W-1:0] chn,
                                  input logic [LBA_W-1:0] s0, input logic [LBA_W-1:0] s1,
                                  input logic [LBA_W-1:0] s2, input logic [LBA_W-1:0] s3);
    write_reg(CFG_PRESENT, CFG_DATA_W'(pres));
    write_reg(CFG_LBA_CAP, CFG_DATA_W'(cap));
    write_reg(CFG_SLAVE,   CFG_DATA_W'(slv));
    write_reg(CFG_CHANNEL, CFG_DATA_W'(chn));
    write_reg(CFG_SECT0, s0);
    write_reg(CFG_SECT1, s1);
    write_reg(CFG_SECT2, s2);
    write_reg(CFG_SECT3, s3);
  endtask

  function automatic logic [LBA_W-1:0] pick_drive_size();
    case ($urandom_range(3))
      0:       return 32'hFFFF_FFFF;
      1:       return $urandom;
      2:       return $urandom_range(32'h0FFF_FFFF);
      default: return $urandom_range(5000);
    endcase
  endfunction

  task automatic load_random_setup();
    logic [MASK_W-1:0] pres;
    // mostly every drive present so requests get past the presence check
    pres = ($urandom_range(3) == 0) ? MASK_W'($urandom) : 4'hF;
    load_drive_setup(pres, MASK_W'($urandom), MASK_W'($urandom), MASK_W'($urandom),
                     pick_drive_size(), pick_drive_size(), pick_drive_size(),
                     pick_drive_size());
  endtask

  task automatic queue_req(input logic op, input logic [DRV_W-1:0] drv,
                           input logic [LBA_W-1:0] lba, input logic [CNT_W-1:0] cnt);
    pending_reqs.push_back(ata_req_t'{op, drv, lba, cnt});
    reqs_queued++;
  endtask

  // Mostly requests that fit a present drive, spread over the three address
  // modes and their edges; the rest is unconstrained noise.
  task automatic queue_random_reqs(input int n);
    ata_req_t         r;
    logic [LBA_W-1:0] size;
    for (int k = 0; k < n; k++) begin
      r.op  = 1'($urandom);
      r.drv = DRV_W'($urandom);
      r.lba = $urandom;
      r.cnt = CNT_W'($urandom);
      if ($urandom_range(99) < 85) begin
        if (present_m != '0) begin
          while (!present_m[r.drv]) r.drv = DRV_W'($urandom);
        end
        size = drive_size[r.drv];
        case ($urandom_range(7))
          0, 1, 2: r.lba = $urandom_range(32'h0FFF_FFFF);
          3:       r.lba = $urandom_range(2100);
          4:       r.lba = LBA48_START - 32'd64 + $urandom_range(127);
          5:       r.lba = size - r.cnt - $urandom_range(2);
          6:       r.lba = ~LBA_W'($urandom_range(300));
          default: ;
        endcase
        // fold into range on most tries, keep a few boundary misses
        if ({1'b0, r.lba} + r.cnt > {1'b0, size} && $urandom_range(3) != 0) begin
          if (size >= r.cnt) begin
            r.lba = r.lba % (size - r.cnt + 32'd1);
          end else begin
            r.lba = '0;
            r.cnt = size[CNT_W-1:0];
          end
        end
      end
      queue_req(r.op, r.drv, r.lba, r.cnt);
    end
  endtask

  // Hold until every request went in and every expected write came out.
  task automatic wait_drained();
    @(negedge clk);
    while (reqs_taken != reqs_queued || writes_due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Request driver: advance to the next pending request once the current
  // transfer completed, idle at random per the current phase.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        req_ch.op           <= next_req.op;
        req_ch.drive_index  <= next_req.drv;
        req_ch.lba          <= next_req.lba;
        req_ch.sector_count <= next_req.cnt;
        req_ch.valid        <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result side backpressure
  always @(posedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else     res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: predict on each request transfer, check each result transfer
  // against the oldest outstanding write.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        build_taskfile_writes(ata_req_t'{req_ch.op, req_ch.drive_index, req_ch.lba,
                                         req_ch.sector_count});
        reqs_taken++;
      end
      if (res_ch.valid && res_ch.ready) begin
        seen_write = tf_write_t'{res_ch.channel_sel, res_ch.reg_select, res_ch.reg_value,
                                 res_ch.error_code, res_ch.last};
        if (writes_due.size() == 0) begin
          $display("%0t: unexpected register write %p", $time, seen_write);
          fail_count++;
        end else begin
          due_write = writes_due.pop_front();
          if (seen_write.ch !== due_write.ch || seen_write.sel !== due_write.sel ||
              seen_write.val !== due_write.val || seen_write.err !== due_write.err ||
              seen_write.last !== due_write.last) begin
            $display("%0t: mismatch expected %p actual %p", $time, due_write, seen_write);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    req_ch.valid  = 1'b0;
    req_ch.op     = OP_READ;
    req_ch.drive_index  = '0;
    req_ch.lba          = '0;
    req_ch.sector_count = '0;
    res_ch.ready  = 1'b0;
    present_m = '0;
    lba_cap_m = '0;
    slave_m   = '0;
    chan_m    = '0;
    foreach (drive_size[d]) drive_size[d] = '0;
    reqs_queued   = 0;
    reqs_taken    = 0;
    fail_count    = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: drive 0 LBA master primary, drive 1 CHS slave primary,
    // drive 2 absent, drive 3 LBA slave secondary with a tiny disk.
    load_drive_setup(4'b1011, 4'b1001, 4'b1010, 4'b1100,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd12345, 32'd1000);
    queue_req(OP_READ,  2'd0, 32'h0000_0000, 8'd0);     // zero sector count
    queue_req(OP_WRITE, 2'd0, 32'h0000_0000, 8'd255);
    queue_req(OP_READ,  2'd0, 32'h0FFF_FFFF, 8'd1);     // top of LBA28
    queue_req(OP_WRITE, 2'd0, 32'h1000_0000, 8'd8);     // first LBA48 address
    queue_req(OP_READ,  2'd0, 32'hFFFF_FF00, 8'd255);   // ends exactly at disk end
    queue_req(OP_WRITE, 2'd0, 32'hFFFF_FFFF, 8'd1);     // sum carries into bit 32
    queue_req(OP_READ,  2'd0, 32'hFFFF_FFFF, 8'd0);
    queue_req(OP_WRITE, 2'd0, 32'hA5A5_5A5A, 8'h5A);
    queue_req(OP_READ,  2'd1, 32'd0, 8'd1);             // CHS track and head edges
    queue_req(OP_WRITE, 2'd1, 32'd62, 8'd2);
    queue_req(OP_READ,  2'd1, 32'd63, 8'd3);
    queue_req(OP_WRITE, 2'd1, 32'd1007, 8'd4);
    queue_req(OP_READ,  2'd1, 32'd1008, 8'd5);
    queue_req(OP_WRITE, 2'd1, 32'h0FFF_FFFF, 8'd6);     // cylinder wraps past 16 bits
    queue_req(OP_READ,  2'd1, 32'h0123_4567, 8'd200);
    queue_req(OP_WRITE, 2'd1, 32'h1000_0000, 8'd7);     // LBA48 on a CHS-only drive
    queue_req(OP_READ,  2'd2, 32'd0, 8'd1);             // absent drive
    queue_req(OP_WRITE, 2'd2, 32'hFFFF_FFFF, 8'hFF);
    queue_req(OP_READ,  2'd3, 32'd900, 8'd100);         // fits exactly
    queue_req(OP_WRITE, 2'd3, 32'd900, 8'd101);         // one past the end
    queue_req(OP_READ,  2'd3, 32'd1000, 8'd0);
    queue_req(OP_WRITE, 2'd3, 32'd1001, 8'd0);
    queue_req(OP_WRITE, 2'd3, 32'h1000_0000, 8'd1);
    wait_drained();

    load_random_setup();
    queue_random_reqs(35);
    wait_drained();

    // All drives present, CHS only, slave, secondary, maximum size
    send_idle_pct = 72;
    load_drive_setup(4'hF, 4'h0, 4'hF, 4'hF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random_reqs(35);
    wait_drained();

    send_idle_pct = 0;
    stall_pct     = 72;
    load_random_setup();
    queue_random_reqs(35);
    wait_drained();

    // Everything cleared: no drive present, zero sizes
    send_idle_pct = 19;
    stall_pct     = 19;
    load_drive_setup(4'h0, 4'h0, 4'h0, 4'h0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_random_reqs(6);
    wait_drained();

    // Present LBA drives with size zero: only an empty request at LBA 0 fits
    load_drive_setup(4'hF, 4'hF, 4'h0, 4'h0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_req(OP_READ, 2'd0, 32'd0, 8'd0);
    queue_req(OP_WRITE, 2'd3, 32'd0, 8'd1);
    queue_random_reqs(4);
    wait_drained();

    load_random_setup();
    queue_random_reqs(35);
    wait_drained();

    send_idle_pct = 0;
    stall_pct     = 0;
    load_random_setup();
    queue_random_reqs(35);
    wait_drained();

    // let any stray write show up before the verdict
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/atacb_pkg.sv
rtl/atacb_if.sv
rtl/ata_taskfile_command_builder.sv
verif/tb.sv
